### rtl/core/dsp_pkg.sv
// Package: shared types and constants for the shortest path core
package dsp_pkg;
  localparam int MaxNodesDef   = 64;
  localparam int MaxEdgesDef   = 256;
  localparam int WeightBitsDef = 16;
  localparam int DistW         = 24;
  localparam logic [DistW-1:0] LimitReset = 24'd999;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_DIST_LIMIT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [5:0]  edge_from;
    logic [5:0]  edge_to;
    logic [15:0] edge_weight;
    logic [5:0]  start_node;
  } dsp_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  node_index;
    logic [23:0] distance;
    logic        unreachable;
    logic        last;
  } dsp_out_t;
endpackage

### rtl/core/dsp_relax.sv
// Shared compare/add unit: min-select step and edge relaxation step
module dsp_relax import dsp_pkg::*; (
  input  logic             sel_mode,
  input  logic [DistW-1:0] cur_dist,
  input  logic [DistW-1:0] ref_dist,
  input  logic [32:0]      add_in,
  output logic             less,
  output logic [DistW-1:0] sum_val
);
  logic [33:0] sum_w;
  always_comb begin
    sum_w   = {10'd0, ref_dist} + {1'b0, add_in};
    sum_val = sum_w[DistW-1:0];
    if (sel_mode) less = cur_dist < ref_dist;
    else less = sum_w < {10'd0, cur_dist};
  end
endmodule

### rtl/core/dijkstra_shortest_paths_core.sv
// Top level: Dijkstra single-source shortest path core
//
// Usage: input beats on in_valid/in_stall/in_data. func=load stores one edge
// and returns one status beat. func=run computes distances from start_node
// and returns one beat per node in use (node 0 first, last flagged), or a single
// status beat if start_node is out of range.
// Config writes (cfg_we, cfg_index, cfg_wdata) only while idle.
// A load or a bad run gives its beat the cycle after accept; the
// next beat is accepted only once that one is taken.
// A run: an init sweep over the nodes, then per settled node a minimum scan
// over the nodes (read, compare) and, if edges are stored, an edge sweep over
// the stored edges (edge read, distance read, compare/add/write), all
// through the single compare/add unit; one closing scan, then per output
// beat a distance read and the beat, and a closing state before idle.
// The memories give one read per cycle; that sets the rate, but out_stall can hold the output beats.
// in_stall is high whenever the core is busy or an output beat waits.
// out_stall holds the output register; the core waits until it's taken.
// Reset (rst_n low, synchronous) clears edge_count, registers to
// node_count=64 and limit=999, and the control state. No clearing pass.
module dijkstra_shortest_paths_core import dsp_pkg::*; #(
  parameter int MAX_NODES   = MaxNodesDef,
  parameter int MAX_EDGES   = MaxEdgesDef,
  parameter int WEIGHT_BITS = WeightBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  dsp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output dsp_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_wdata
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int NC = $clog2(MAX_NODES + 1);
  localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC = $clog2(MAX_EDGES + 1);
  localparam int ENTW = 12 + WEIGHT_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_SCAN, S_RELAX, S_EMIT, S_OUT
  } state_t;

  state_t           state_r;
  logic [6:0]       node_count_r;
  logic [DistW-1:0] limit_r;
  logic [EC-1:0]    edge_count_r;
  logic [NC-1:0]    n_r;
  logic [NC-1:0]    idx_r;
  logic [EC-1:0]    eidx_r;
  logic [5:0]       start_r;
  logic [DistW-1:0] best_d_r;
  logic [NC-1:0]    best_r;
  logic [MAX_NODES-1:0] settled_r;
  logic [1:0]       rd_ph_r;
  logic             out_valid_r;
  dsp_out_t         out_r;

  logic [ENTW-1:0]  etab [MAX_EDGES];
  logic [DistW-1:0] dist_mem [MAX_NODES];
  logic [ENTW-1:0]  e_rd;
  logic [DistW-1:0] d_rd;

  // effective register values
  logic [NC-1:0]    n_eff;
  logic [DistW-1:0] lim_eff;
  always_comb begin
    if (node_count_r == 7'd0) n_eff = NC'(1);
    else if ({25'd0, node_count_r} > 32'(MAX_NODES)) n_eff = NC'(MAX_NODES);
    else n_eff = NC'(node_count_r);
    lim_eff = (limit_r == '0) ? DistW'(1) : limit_r;
  end

  logic [5:0] e_from, e_to;
  logic [WEIGHT_BITS-1:0] e_w;
  assign e_from = e_rd[ENTW-1 -: 6];
  assign e_to   = e_rd[ENTW-7 -: 6];
  assign e_w    = e_rd[WEIGHT_BITS-1:0];

  // shared unit: scan compares d_rd against best; relax compares best+w vs d_rd
  logic             u_sel, u_less;
  logic [DistW-1:0] u_sum, u_cur, u_ref;
  logic [32:0]      u_add;
  always_comb begin
    u_sel = (state_r == S_SCAN);
    u_cur = d_rd;
    u_ref = best_d_r;
    u_add = 33'(e_w);
  end
  dsp_relax u_relax (
    .sel_mode(u_sel), .cur_dist(u_cur), .ref_dist(u_ref), .add_in(u_add),
    .less(u_less), .sum_val(u_sum)
  );

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic accept;
  assign accept = in_valid && !in_stall;

  // input checks: endpoint range before table full; start node range
  logic       in_bad, run_bad;
  logic [1:0] load_status;
  always_comb begin
    in_bad  = ({1'b0, in_data.edge_from} >= 7'(n_eff)) ||
              ({1'b0, in_data.edge_to} >= 7'(n_eff));
    run_bad = ({1'b0, in_data.start_node} >= 7'(n_eff));
    load_status = ST_OK;
    if (in_bad) load_status = ST_BAD;
    else if (edge_count_r == EC'(MAX_EDGES)) load_status = ST_FULL;
  end

  // memory addresses
  logic [NW-1:0] d_raddr;
  logic [EW-1:0] e_raddr;
  logic [NC-1:0] idx_inc;
  logic [EC-1:0] eidx_inc;
  assign idx_inc  = idx_r + NC'(1);
  assign eidx_inc = eidx_r + EC'(1);
  always_comb begin
    d_raddr = idx_r[NW-1:0];
    if (state_r == S_RELAX) d_raddr = e_to[NW-1:0];
    e_raddr = eidx_r[EW-1:0];
  end

  logic             e_we, d_we;
  logic [EW-1:0]    e_waddr;
  logic [ENTW-1:0]  e_wdata;
  logic [NW-1:0]    d_waddr;
  logic [DistW-1:0] d_wdata;

  always_ff @(posedge clk) begin
    if (e_we) etab[e_waddr] <= e_wdata;
    e_rd <= etab[e_raddr];
  end
  always_ff @(posedge clk) begin
    if (d_we) dist_mem[d_waddr] <= d_wdata;
    d_rd <= dist_mem[d_raddr];
  end

  logic edge_ok;
  assign edge_ok = ({1'b0, e_from} < 7'(n_r)) && ({1'b0, e_to} < 7'(n_r)) &&
                   (e_from[NW-1:0] == best_r[NW-1:0]) &&
                   ({1'b0, e_from} == 7'(best_r));

  // scan: unsettled node strictly below the best so far (ties keep lower index)
  logic          scan_hit;
  logic [NW-1:0] settle_idx;
  assign scan_hit   = !settled_r[idx_r[NW-1:0]] && u_less;
  assign settle_idx = scan_hit ? idx_r[NW-1:0] : best_r[NW-1:0];

  // output beat launches
  logic             emit_go, beat_go;
  logic             emit_unr;
  logic [DistW-1:0] emit_dist;
  always_comb begin
    emit_go   = (state_r == S_EMIT) && (rd_ph_r == 2'd1) &&
                (!out_valid_r || !out_stall);
    beat_go   = (accept && (in_data.func == FUNC_LOAD || run_bad)) || emit_go;
    emit_unr  = (d_rd >= lim_eff);
    emit_dist = emit_unr ? lim_eff : d_rd;
  end

  always_comb begin
    e_we    = 1'b0;
    e_waddr = edge_count_r[EW-1:0];
    e_wdata = {in_data.edge_from, in_data.edge_to,
               in_data.edge_weight[WEIGHT_BITS-1:0]};
    d_we    = 1'b0;
    d_waddr = idx_r[NW-1:0];
    d_wdata = ({1'b0, start_r} == 7'(idx_r)) ? '0 : lim_eff;
    if (accept && in_data.func == FUNC_LOAD && load_status == ST_OK)
      e_we = 1'b1;
    if (state_r == S_INIT) d_we = 1'b1;
    // phase 2: edge in e_rd, target distance in d_rd
    if (state_r == S_RELAX && rd_ph_r == 2'd2 && edge_ok && u_less) begin
      d_we    = 1'b1;
      d_waddr = e_to[NW-1:0];
      d_wdata = u_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= 7'd64;
      limit_r      <= LimitReset;
      edge_count_r <= '0;
      out_valid_r  <= 1'b0;
      settled_r    <= '0;
      rd_ph_r      <= 2'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT) node_count_r <= cfg_wdata[6:0];
        else limit_r <= cfg_wdata;
      end
      if (beat_go) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            n_r     <= n_eff;
            start_r <= in_data.start_node;
            if (in_data.func == FUNC_LOAD) begin
              out_r <= '{status: load_status, node_index: 6'd0,
                         distance: 24'd0, unreachable: 1'b0, last: 1'b1};
              if (load_status == ST_OK) edge_count_r <= edge_count_r + EC'(1);
            end else if (run_bad) begin
              out_r <= '{status: ST_BAD, node_index: 6'd0,
                         distance: 24'd0, unreachable: 1'b0, last: 1'b1};
            end else begin
              idx_r   <= '0;
              state_r <= S_INIT;
            end
          end
        end
        S_INIT: begin
          settled_r[idx_r[NW-1:0]] <= 1'b0;
          if (idx_inc == n_r) begin
            idx_r    <= '0;
            rd_ph_r  <= 2'd0;
            best_d_r <= lim_eff;
            best_r   <= n_r;
            state_r  <= S_SCAN;
          end else begin
            idx_r <= idx_inc;
          end
        end
        S_SCAN: begin
          // read issued at idx_r, data next cycle; rd_ph_r marks data valid
          if (rd_ph_r == 2'd0) begin
            rd_ph_r <= 2'd1;
          end else begin
            rd_ph_r <= 2'd0;
            if (idx_inc != n_r) begin
              idx_r <= idx_inc;
              if (scan_hit) begin
                best_d_r <= d_rd;
                best_r   <= idx_r;
              end
            end else begin
              idx_r <= '0;
              if (best_r == n_r && !scan_hit) begin
                state_r <= S_EMIT;
              end else begin
                settled_r[settle_idx] <= 1'b1;
                eidx_r <= '0;
                if (edge_count_r == '0) begin
                  // nothing to relax, scan again
                  best_d_r <= lim_eff;
                  best_r   <= n_r;
                end else begin
                  if (scan_hit) begin
                    best_d_r <= d_rd;
                    best_r   <= idx_r;
                  end
                  state_r <= S_RELAX;
                end
              end
            end
          end
        end
        S_RELAX: begin
          // phase0: edge read; phase1: target distance read; phase2: relax
          if (rd_ph_r != 2'd2) begin
            rd_ph_r <= rd_ph_r + 2'd1;
          end else begin
            rd_ph_r <= 2'd0;
            if (eidx_inc == edge_count_r) begin
              best_d_r <= lim_eff;
              best_r   <= n_r;
              idx_r    <= '0;
              state_r  <= S_SCAN;
            end else begin
              eidx_r <= eidx_inc;
            end
          end
        end
        S_EMIT: begin
          if (rd_ph_r == 2'd0) begin
            rd_ph_r <= 2'd1;
          end else if (emit_go) begin
            rd_ph_r <= 2'd0;
            out_r   <= '{status: ST_OK, node_index: 6'(idx_r),
                         distance: emit_dist, unreachable: emit_unr,
                         last: (idx_inc == n_r)};
            idx_r   <= idx_inc;
            if (idx_inc == n_r) state_r <= S_OUT;
          end
        end
        S_OUT: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### tb/tb_dijkstra_shortest_paths_core.sv
// Testbench for the Dijkstra shortest path core: self-checking, randomized beats
`timescale 1ns / 1ps

module tb_dijkstra_shortest_paths_core;
  import dsp_pkg::*;

  localparam int NodesMax   = 64;
  localparam int EdgesMax   = 256;
  localparam int CycleLimit = 20000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  dsp_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  dsp_out_t    out_data;
  logic        cfg_we;
  logic        cfg_index;
  logic [23:0] cfg_wdata;

  dijkstra_shortest_paths_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the graph and registers, used to predict distances
  // ---------------------------------------------------------------------
  logic [5:0]  graph_from   [EdgesMax];
  logic [5:0]  graph_to     [EdgesMax];
  logic [15:0] graph_weight [EdgesMax];
  int unsigned graph_edges;
  logic [6:0]  node_count_reg;
  logic [23:0] dist_limit_reg;

  dsp_out_t    expected_beats[$];   // predicted output beats, oldest first
  int unsigned fail_count;
  int unsigned cycle_count;

  // idle percentages for each side, and a long receiver hold-off counter
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold_cycles;

  function automatic int unsigned nodes_in_use();
    if (node_count_reg == 7'd0) return 1;
    if (node_count_reg > NodesMax) return NodesMax;
    return node_count_reg;
  endfunction

  function automatic longint unsigned limit_in_use();
    return (dist_limit_reg == 24'd0) ? 64'd1 : 64'(dist_limit_reg);
  endfunction

  function automatic dsp_in_t rand_item();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(dsp_in_t)-1:0];
  endfunction

  function automatic void enqueue_beat(dsp_out_t b);
    expected_beats = {expected_beats, b};
  endfunction

  function automatic void push_status(logic [1:0] st);
    dsp_out_t b;
    b = '0;
    b.status = st;
    b.last   = 1'b1;
    enqueue_beat(b);
  endfunction

  // Edge load: range check first, then table-full check
  function automatic void predict_load(dsp_in_t it);
    int unsigned n;
    n = nodes_in_use();
    if (it.edge_from >= n || it.edge_to >= n) begin
      push_status(ST_BAD);
    end else if (graph_edges >= EdgesMax) begin
      push_status(ST_FULL);
    end else begin
      graph_from[graph_edges]   = it.edge_from;
      graph_to[graph_edges]     = it.edge_to;
      graph_weight[graph_edges] = it.edge_weight;
      graph_edges++;
      push_status(ST_OK);
    end
  endfunction

  // Run: settle the least unsettled node (lowest index on ties), relax its edges
  function automatic void predict_paths(logic [5:0] start);
    longint unsigned path_len [NodesMax];
    bit              settled [NodesMax];
    longint unsigned lim, best_d, cand;
    int unsigned     n, best;
    dsp_out_t        b;
    n   = nodes_in_use();
    lim = limit_in_use();
    if (start >= n) begin
      push_status(ST_BAD);
      return;
    end
    for (int i = 0; i < n; i++) begin
      path_len[i] = lim;
      settled[i]  = 1'b0;
    end
    path_len[start] = 0;
    forever begin
      best   = n;
      best_d = lim;
      for (int i = 0; i < n; i++) begin
        if (!settled[i] && path_len[i] < best_d) begin
          best_d = path_len[i];
          best   = i;
        end
      end
      if (best == n) break;
      settled[best] = 1'b1;
      // edges touching nodes beyond a shrunk node_count are skipped
      for (int e = 0; e < graph_edges; e++) begin
        if (graph_from[e] == best && graph_to[e] < n) begin
          cand = best_d + graph_weight[e];
          if (cand < path_len[graph_to[e]]) path_len[graph_to[e]] = cand;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      b             = '0;
      b.status      = ST_OK;
      b.node_index  = i[5:0];
      b.unreachable = (path_len[i] >= lim);
      b.distance    = b.unreachable ? lim[23:0] : path_len[i][23:0];
      b.last        = (i == n - 1);
      enqueue_beat(b);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driving helpers (inputs change on the falling edge)
  // ---------------------------------------------------------------------
  task automatic send_beat(dsp_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= rand_item();
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    // accepted at this edge; predict before any resulting beat can appear
    if (it.func == FUNC_LOAD) predict_load(it);
    else predict_paths(it.start_node);
  endtask

  task automatic load_edge(int unsigned a, int unsigned b, int unsigned w);
    dsp_in_t it;
    it             = rand_item();  // unused fields random
    it.func        = FUNC_LOAD;
    it.edge_from   = a[5:0];
    it.edge_to     = b[5:0];
    it.edge_weight = w[15:0];
    send_beat(it);
  endtask

  task automatic run_from(int unsigned s);
    dsp_in_t it;
    it            = rand_item();
    it.func       = FUNC_RUN;
    it.start_node = s[5:0];
    send_beat(it);
  endtask

  // Drop valid, then wait until every predicted beat came back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  // Register write; callers drain first so the core is idle
  task automatic write_reg(logic idx, int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[23:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_NODE_COUNT) node_count_reg = val[6:0];
    else dist_limit_reg = val[23:0];
  endtask

  task automatic report(string what, longint unsigned exp_v, longint unsigned got_v);
    $display("mismatch at cycle %0d: %s expected %0d got %0d",
             cycle_count, what, exp_v, got_v);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off counted here
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      out_stall        <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Output checker: every taken beat against the oldest prediction
  always @(posedge clk) begin
    dsp_out_t exp_b;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat, status", 0, out_data.status);
      end else begin
        exp_b = expected_beats.pop_front();
        if (out_data.status != exp_b.status)
          report("status", exp_b.status, out_data.status);
        if (out_data.node_index != exp_b.node_index)
          report("node_index", exp_b.node_index, out_data.node_index);
        if (out_data.distance != exp_b.distance)
          report("distance", exp_b.distance, out_data.distance);
        if (out_data.unreachable != exp_b.unreachable)
          report("unreachable", exp_b.unreachable, out_data.unreachable);
        if (out_data.last != exp_b.last)
          report("last", exp_b.last, out_data.last);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("** dijkstra_shortest_paths_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Empty graph at reset size: only the start is reachable; highest start node
  task automatic test_reset_state();
    run_from(63);
    drain();
  endtask

  // Small graph with extreme weights, out-of-range endpoints and start nodes
  task automatic test_edge_loads();
    write_reg(CFG_NODE_COUNT, 8);
    load_edge(0, 1, 5);
    load_edge(1, 2, 0);
    load_edge(0, 2, 65535);
    load_edge(2, 7, 100);
    load_edge(7, 0, 1);
    load_edge(9, 1, 3);        // bad source
    load_edge(1, 63, 3);       // bad destination
    load_edge(3, 3, 0);        // self loop
    run_from(0);
    run_from(7);
    run_from(63);              // bad start
    run_from(8);               // bad start, just over
    drain();
  endtask

  // Register extremes, including the out-of-range ones that get clamped
  task automatic test_registers();
    write_reg(CFG_DIST_LIMIT, 0);          // acts as 1
    run_from(0);
    drain();
    write_reg(CFG_DIST_LIMIT, 16777215);
    write_reg(CFG_NODE_COUNT, 0);          // acts as 1
    load_edge(0, 0, 7);
    load_edge(0, 1, 7);
    run_from(0);
    run_from(1);
    drain();
    write_reg(CFG_NODE_COUNT, 127);        // acts as 64
    load_edge(63, 62, 65535);
    run_from(7);
    drain();
    write_reg(CFG_DIST_LIMIT, 100);        // long paths cut at the limit
    write_reg(CFG_NODE_COUNT, 3);          // shrunk: edge to node 7 ignored
    run_from(0);
    drain();
  endtask

  // One random phase: mostly loads that stay in range, some runs, some noise
  task automatic test_random_phase(int unsigned items);
    int unsigned n, pick;
    for (int k = 0; k < items; k++) begin
      if (k % 15 == 0) begin
        drain();
        pick = $urandom_range(9);
        n    = (pick == 0) ? 64 : $urandom_range(2, 12);
        write_reg(CFG_NODE_COUNT, n);
        write_reg(CFG_DIST_LIMIT, ($urandom_range(1) == 1) ?
                  $urandom_range(16777215) : $urandom_range(1, 300));
      end
      n    = nodes_in_use();
      pick = $urandom_range(99);
      if (pick < 70) begin
        load_edge($urandom_range(n - 1), $urandom_range(n - 1),
                  ($urandom_range(1) == 1) ? $urandom_range(65535)
                                           : $urandom_range(60));
      end else if (pick < 78) begin
        load_edge($urandom_range(63), $urandom_range(63), $urandom_range(65535));
      end else if (pick < 96) begin
        run_from($urandom_range(n - 1));
      end else begin
        run_from($urandom_range(63));
      end
    end
    drain();
  endtask

  // Receiver holds off long while loads keep coming, so the core backs up
  task automatic test_backpressure();
    write_reg(CFG_NODE_COUNT, 6);
    recv_hold_cycles = 300;
    for (int k = 0; k < 8; k++)
      load_edge($urandom_range(5), $urandom_range(5), $urandom_range(65535));
    run_from(0);
    drain();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_data          = '0;
    out_stall        = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_NODE_COUNT;
    cfg_wdata        = '0;
    fail_count       = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    recv_idle_pct    = 0;
    recv_hold_cycles = 0;
    graph_edges      = 0;
    node_count_reg   = 7'd64;
    dist_limit_reg   = LimitReset;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 59;
    test_reset_state();
    test_edge_loads();
    test_registers();
    test_random_phase(37);

    send_idle_pct = 59;
    recv_idle_pct = 34;
    test_random_phase(37);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(37);

    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_beats.size() == 0) begin
      $display("** dijkstra_shortest_paths_core: PASSED **");
    end else begin
      $display("** dijkstra_shortest_paths_core: FAILED **");
    end
    $finish;
  end

endmodule
